FILE: rtl/scm_pkg.sv
// Shared types, constants and helpers for the sin/cos encoder calibration monitor.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

	// fixed-point formats of the mean and offset words
	localparam int MEAN_FRAC   = 28;
	localparam int OFFSET_FRAC = 12;
	localparam int MEAN_SHIFT  = MEAN_FRAC - OFFSET_FRAC;

	localparam logic signed [31:0] AVG_INIT = 32'sh2000_0000;  // 2.0 in Q3.28
	localparam logic [31:0]        MAG_LOW_INIT = 32'hFFFF_FFFF;

	localparam int CFG_DATA_WIDTH  = 32;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_REPORT = 1'b1
	} scm_op_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_COEFF   = 2'd0,
		REG_AUTOCAL = 2'd1,
		REG_SIN_OFF = 2'd2,
		REG_COS_OFF = 2'd3
	} scm_reg_t;

	// per-item controls from the top level to the datapath units
	typedef struct packed {
		logic upd;  // sample item being processed
		logic clr;  // report item being processed: clear extremes after it
	} scm_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -34'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/scm_magnitude.sv
// Squared magnitude and its running extremes.
`timescale 1ns / 1ps
`default_nettype none

module scm_magnitude import scm_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire scm_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sin_val,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cos_val,
	output logic [31:0]                    msq,
	output logic [31:0]                    mag_min,
	output logic [31:0]                    mag_max,
	output logic signed [32:0]             mag_spread
);

	localparam int SQW = 2 * SAMPLE_WIDTH;

	logic [SQW-1:0] sq_s, sq_c;
	logic [SQW:0]   sq_sum;
	logic [64:0]    sq_wide;
	logic [31:0]    msq_raw;
	logic [31:0]    lo_q, hi_q, lo_nx, hi_nx;

	assign sq_s    = sin_val * sin_val;
	assign sq_c    = cos_val * cos_val;
	assign sq_sum  = {1'b0, sq_s} + {1'b0, sq_c};
	assign sq_wide = 65'(sq_sum);
	assign msq_raw = sq_wide[31:0];

	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (ctl.upd) begin
			if (msq_raw < lo_q) lo_nx = msq_raw;
			if (msq_raw > hi_q) hi_nx = msq_raw;
		end
	end

	assign msq        = ctl.upd ? msq_raw : 32'd0;
	assign mag_min    = lo_nx;
	assign mag_max    = hi_nx;
	assign mag_spread = $signed({1'b0, hi_nx}) - $signed({1'b0, lo_nx});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= MAG_LOW_INIT;
			hi_q <= 32'd0;
		end else if (ctl.clr) begin
			lo_q <= MAG_LOW_INIT;
			hi_q <= 32'd0;
		end else begin
			lo_q <= lo_nx;
			hi_q <= hi_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/scm_channel.sv
// One encoder channel: extremes, exponential mean filter and offset tracking.
`timescale 1ns / 1ps
`default_nettype none

module scm_channel import scm_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire scm_ctl_t                       ctl,
	input  wire logic [COEFF_WIDTH-1:0]         coeff,
	input  wire                                 autocal,
	input  wire                                 off_load,
	input  wire logic signed [31:0]             off_value,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic signed [SAMPLE_WIDTH:0]        amplitude,
	output logic signed [31:0]                  mean_total,
	output logic signed [31:0]                  offset_now
);

	localparam int ALIGN    = MEAN_FRAC - (SAMPLE_WIDTH - 4);
	localparam int PW       = COEFF_WIDTH + 34;
	localparam int LOW_INIT = (SAMPLE_WIDTH > 16) ? 32767 : (2 ** (SAMPLE_WIDTH - 1)) - 1;

	logic signed [SAMPLE_WIDTH-1:0] lo_q, hi_q, lo_nx, hi_nx;
	logic signed [31:0] avg_q, avg_new, avg_nx;
	logic signed [31:0] offset_q, off_new, offset_nx;
	logic signed [31:0] aligned;
	logic signed [32:0] diff;
	logic signed [PW-1:0] prod, prod_rnd;
	logic signed [33:0] delta;
	logic signed [32:0] mq_rnd;
	logic signed [16:0] mq;

	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (ctl.upd) begin
			if (sample > hi_q) hi_nx = sample;
			if (sample < lo_q) lo_nx = sample;
		end
	end

	// avg*(1-k) + k*x == avg + k*(x - avg); avg is a whole multiple before rounding
	assign aligned  = 32'(sample) <<< ALIGN;
	assign diff     = 33'(aligned) - 33'(avg_q);
	assign prod     = $signed({1'b0, coeff}) * diff;
	assign prod_rnd = prod + (PW'(1) <<< (COEFF_WIDTH - 1));
	assign delta    = 34'(prod_rnd >>> COEFF_WIDTH);
	assign avg_new  = 32'(34'(avg_q) + delta);
	assign avg_nx   = ctl.upd ? avg_new : avg_q;

	// Q3.28 mean rounded to Q4.12, ties up
	assign mq_rnd = 33'(avg_nx) + (33'sd1 <<< (MEAN_SHIFT - 1));
	assign mq     = mq_rnd[32:MEAN_SHIFT];

	assign off_new   = sat32(34'(mq) + 34'(offset_q));
	assign offset_nx = (ctl.upd && autocal) ? off_new : offset_q;

	assign mean_total = sat32(34'(mq) + 34'(offset_nx));
	assign offset_now = offset_nx;
	assign amplitude  = (SAMPLE_WIDTH + 1)'(hi_nx) - (SAMPLE_WIDTH + 1)'(lo_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= SAMPLE_WIDTH'(LOW_INIT);
			hi_q     <= '0;
			avg_q    <= AVG_INIT;
			offset_q <= '0;
		end else begin
			if (ctl.clr) begin
				lo_q <= SAMPLE_WIDTH'(LOW_INIT);
				hi_q <= '0;
			end else begin
				lo_q <= lo_nx;
				hi_q <= hi_nx;
			end
			avg_q <= avg_nx;
			if (off_load)
				offset_q <= off_value;
			else
				offset_q <= offset_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sincos_encoder_calibration_monitor.sv
// Top level of the sin/cos encoder calibration monitor: registers, handshakes, config.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  opcode, sin_sample, cos_sample
//   out      output     out_valid/out_ready  magnitude and channel statistics
//   cfg      input      cfg_we (no stall)    cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an item lands in
// the input register, then its result is registered in the output register.
// The channel mean filters are the critical path: one coeff-by-difference multiply
// per channel plus the offset add, all between the input and result registers.
// A stalled output holds the input register, which still takes a new item
// whenever its content moves on. Reset restores all statistics at once.
`timescale 1ns / 1ps
`default_nettype none

module sincos_encoder_calibration_monitor import scm_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 opcode,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sin_sample,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cos_sample,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [31:0]                         magnitude_sq,
	output logic [31:0]                         magnitude_min,
	output logic [31:0]                         magnitude_max,
	output logic signed [32:0]                  magnitude_spread,
	output logic signed [31:0]                  sin_mean_total,
	output logic signed [31:0]                  cos_mean_total,
	output logic signed [SAMPLE_WIDTH:0]        sin_amplitude,
	output logic signed [SAMPLE_WIDTH:0]        cos_amplitude,
	output logic signed [31:0]                  sin_offset_now,
	output logic signed [31:0]                  cos_offset_now,
	input  wire                                 cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]      cfg_data
);

	logic                           v_s1;
	scm_op_t                        op_s1;
	logic signed [SAMPLE_WIDTH-1:0] sin_s1, cos_s1;
	logic                           out_valid_q;
	logic                           adv, fire;
	scm_ctl_t                       ctl;

	logic [COEFF_WIDTH-1:0] coeff_q;
	logic                   autocal_q;
	logic                   wr_coeff, wr_autocal, ld_sin, ld_cos;

	logic [31:0]                  msq, mmin, mmax;
	logic signed [32:0]           mspread;
	logic signed [31:0]           s_total, c_total, s_off, c_off;
	logic signed [SAMPLE_WIDTH:0] s_amp, c_amp;

	assign adv      = !out_valid_q || out_ready;
	assign fire     = v_s1 && adv;
	assign in_ready = !v_s1 || adv;
	assign ctl.upd  = fire && (op_s1 == OP_SAMPLE);
	assign ctl.clr  = fire && (op_s1 == OP_REPORT);

	always_comb begin
		wr_coeff   = 1'b0;
		wr_autocal = 1'b0;
		ld_sin     = 1'b0;
		ld_cos     = 1'b0;
		if (cfg_we) begin
			unique case (scm_reg_t'(cfg_index))
				REG_COEFF:   wr_coeff   = 1'b1;
				REG_AUTOCAL: wr_autocal = 1'b1;
				REG_SIN_OFF: ld_sin     = 1'b1;
				REG_COS_OFF: ld_cos     = 1'b1;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q   <= COEFF_WIDTH'(7);
			autocal_q <= 1'b0;
		end else begin
			if (wr_coeff)   coeff_q   <= cfg_data[COEFF_WIDTH-1:0];
			if (wr_autocal) autocal_q <= cfg_data[0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= scm_op_t'(opcode);
			sin_s1 <= sin_sample;
			cos_s1 <= cos_sample;
		end
	end

	scm_magnitude #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_mag (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sin_val    (sin_s1),
		.cos_val    (cos_s1),
		.msq        (msq),
		.mag_min    (mmin),
		.mag_max    (mmax),
		.mag_spread (mspread)
	);

	scm_channel #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEFF_WIDTH  (COEFF_WIDTH)
	) u_sin (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.coeff      (coeff_q),
		.autocal    (autocal_q),
		.off_load   (ld_sin),
		.off_value  ($signed(cfg_data)),
		.sample     (sin_s1),
		.amplitude  (s_amp),
		.mean_total (s_total),
		.offset_now (s_off)
	);

	scm_channel #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEFF_WIDTH  (COEFF_WIDTH)
	) u_cos (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.coeff      (coeff_q),
		.autocal    (autocal_q),
		.off_load   (ld_cos),
		.off_value  ($signed(cfg_data)),
		.sample     (cos_s1),
		.amplitude  (c_amp),
		.mean_total (c_total),
		.offset_now (c_off)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			magnitude_sq     <= msq;
			magnitude_min    <= mmin;
			magnitude_max    <= mmax;
			magnitude_spread <= mspread;
			sin_mean_total   <= s_total;
			cos_mean_total   <= c_total;
			sin_amplitude    <= s_amp;
			cos_amplitude    <= c_amp;
			sin_offset_now   <= s_off;
			cos_offset_now   <= c_off;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
